/* hdl/segment_segment_distance_squared_top_defines.svh */
// assertion macros for the top-level rtl
`ifndef SEGMENT_SEGMENT_DISTANCE_SQUARED_TOP_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_SQUARED_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ssd assertion failed");
`define SSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ssd implication failed");
`else
`define SSD_ASSERT(lbl, clk, rstn, prop)
`define SSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/ssd_pkg.sv */
package ssd_pkg;

    // result field widths
    localparam int DIST_W         = 41;
    localparam int PARAM_W        = 17;
    // fractional bits of the squared distance
    localparam int DIST_FRAC_BITS = 8;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

/* hdl/ssd_mul.sv */
module ssd_mul #(
    parameter int W = 34
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    // two stages: half-width partial products, then sum and sign
    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;

    logic [W-1:0]        am;
    logic [W-1:0]        bm;
    logic [2*W-1:0]      mag;
    logic [2*LO-1:0]     ll_reg;
    logic [LO+HI-1:0]    lh_reg;
    logic [LO+HI-1:0]    hl_reg;
    logic [2*HI-1:0]     hh_reg;
    logic                neg_reg;
    logic signed [2*W-1:0] p_reg;

    always_comb begin
        am = a[W-1] ? (~a + 1'b1) : a;
        bm = b[W-1] ? (~b + 1'b1) : b;
        mag = ((2*W)'(hh_reg) << (2*LO))
            + (((2*W)'(lh_reg) + (2*W)'(hl_reg)) << LO)
            + (2*W)'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= am[LO-1:0] * bm[LO-1:0];
            lh_reg  <= am[LO-1:0] * bm[W-1:LO];
            hl_reg  <= am[W-1:LO] * bm[LO-1:0];
            hh_reg  <= am[W-1:LO] * bm[W-1:LO];
            neg_reg <= a[W-1] ^ b[W-1];
            p_reg   <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign p = p_reg;

endmodule

/* hdl/ssd_div.sv */
module ssd_div #(
    parameter int W  = 35,
    parameter int FB = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] num,
    input  logic [W-1:0]        den,
    output logic [FB:0]         q
);

    // clamped restoring divide, one quotient bit per stage
    logic [W-1:0]  rem_reg [0:FB];
    logic [W-1:0]  den_reg [0:FB];
    logic [FB-1:0] quo_reg [0:FB];
    logic [FB:0]   zero_reg;
    logic [FB:0]   one_reg;
    logic [W:0]    sh_c [1:FB];
    logic [FB:1]   ge_c;
    logic [W-1:0]  rem_next [1:FB];

    always_comb begin
        for (int i = 1; i <= FB; i++) begin
            sh_c[i]     = {rem_reg[i-1], 1'b0};
            ge_c[i]     = sh_c[i] >= {1'b0, den_reg[i-1]};
            rem_next[i] = ge_c[i] ? W'(sh_c[i] - {1'b0, den_reg[i-1]}) : W'(sh_c[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (num <= 0);
            one_reg[0]  <= (num > 0) && ($unsigned(num) >= den);
            rem_reg[0]  <= $unsigned(num);
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            for (int i = 1; i <= FB; i++) begin
                rem_reg[i]  <= rem_next[i];
                den_reg[i]  <= den_reg[i-1];
                quo_reg[i]  <= {quo_reg[i-1][FB-2:0], ge_c[i]};
                zero_reg[i] <= zero_reg[i-1];
                one_reg[i]  <= one_reg[i-1];
            end
        end
    end

    always_comb begin
        if (one_reg[FB]) begin
            q = {1'b1, {FB{1'b0}}};
        end else if (zero_reg[FB]) begin
            q = '0;
        end else begin
            q = {1'b0, quo_reg[FB]};
        end
    end

endmodule

/* hdl/segment_segment_distance_squared_top.sv */
// closest points between two 2d segments, squared distance
// input channel s_: the four endpoints of segment p (first) and q (second),
//   signed integers, one word per accepted s_valid/s_ready handshake
// result channel m_: squared distance (8 fractional bits, truncated,
//   saturating) and the closest point parameters s and t in q1.frac
// pipeline: every word passes through two chained dividers (s, then t),
//   each PARAM_FRAC_BITS + 1 stages of one quotient bit per stage
// throughput: one word per cycle unless stalled; every stage is registered
//   and valid bits travel alongside the data
// stall: while m_valid is high and m_ready low the whole pipeline
//   freezes and s_ready drops; nothing is lost or repeated
// reset: aresetn (synchronous, active low) clears all valid bits; data
//   registers are not reset
`include "segment_segment_distance_squared_top_defines.svh"

module segment_segment_distance_squared_top #(
    parameter int COORD_WIDTH     = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_first_start_x,
    input  logic signed [COORD_WIDTH-1:0]  s_first_start_y,
    input  logic signed [COORD_WIDTH-1:0]  s_first_end_x,
    input  logic signed [COORD_WIDTH-1:0]  s_first_end_y,
    input  logic signed [COORD_WIDTH-1:0]  s_second_start_x,
    input  logic signed [COORD_WIDTH-1:0]  s_second_start_y,
    input  logic signed [COORD_WIDTH-1:0]  s_second_end_x,
    input  logic signed [COORD_WIDTH-1:0]  s_second_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ssd_pkg::DIST_W-1:0]     m_distance_squared,
    output logic [ssd_pkg::PARAM_W-1:0]    m_first_param,
    output logic [ssd_pkg::PARAM_W-1:0]    m_second_param
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = PARAM_FRAC_BITS;
    // widths of the intermediate quantities
    localparam int DW  = CW + 1;               // coordinate differences
    localparam int PW  = 2 * DW;               // dot products
    localparam int MW  = 2 * PW;               // products of dot products
    localparam int NW  = MW + 1;               // first divider operands
    localparam int AW  = PW + 1;               // small divider operands
    localparam int BSW = (PW > FB + 2) ? PW : FB + 2;
    localparam int TW  = PW + FB + 3;          // t numerator
    localparam int PRW = DW + FB + 2;          // direction times parameter
    localparam int QW  = CW + FB + 4;          // closest point difference
    localparam int SW  = 2 * QW + 1;           // sum of squares
    localparam int DSHIFT = 2 * FB - ssd_pkg::DIST_FRAC_BITS;

    // stage numbers
    localparam int LD = FB + 1;                // divider latency
    localparam int K1 = 6 + LD;                // first dividers done
    localparam int K2 = K1 + 3;                // t numerator registered
    localparam int K3 = K2 + LD;               // t divider done
    localparam int N  = K3 + 5;                // output register

    // geometry slots
    localparam int G_D1X = 0;
    localparam int G_D1Y = 1;
    localparam int G_D2X = 2;
    localparam int G_D2Y = 3;
    localparam int G_RX  = 4;
    localparam int G_RY  = 5;
    // dot product slots
    localparam int C_A = 0;
    localparam int C_B = 1;
    localparam int C_C = 2;
    localparam int C_E = 3;
    localparam int C_F = 4;
    // divider result slots
    localparam int S_S1  = 0;
    localparam int S_LO  = 1;
    localparam int S_HI  = 2;
    localparam int S_DEG = 3;
    // flag bits
    localparam int Z_A      = 1;
    localparam int Z_E      = 0;
    localparam int TF_NEG   = 1;
    localparam int TF_ABOVE = 0;

    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    logic pipe_en;
    logic [N:1] vld_reg;

    logic signed [DW-1:0]  geo_reg  [1:K3][6];
    logic signed [PW-1:0]  prod_reg [10];
    logic signed [PW-1:0]  coef_reg [3:K1+2][5];

    logic signed [MW-1:0]  p_ae;
    logic signed [MW-1:0]  p_bb;
    logic signed [MW-1:0]  p_bf;
    logic signed [MW-1:0]  p_ce;

    logic signed [NW-1:0]  den_reg;
    logic signed [NW-1:0]  n1_reg;
    logic signed [AW-1:0]  nlo_reg;
    logic signed [AW-1:0]  nhi_reg;
    logic [1:0]            zf_reg [6:K3];

    logic [FB:0]           q_s1;
    logic [FB:0]           q_lo;
    logic [FB:0]           q_hi;
    logic [FB:0]           q_deg;
    logic [FB:0]           q_t;
    logic [FB:0]           sel_reg [K1+1:K3][4];

    logic signed [2*BSW-1:0] p_bs;
    logic signed [TW-1:0]  tn_next;
    logic [TW-1:0]         trange_next;
    logic signed [TW-1:0]  tn_reg;
    logic [TW-1:0]         trange_reg;
    logic [1:0]            tf_reg [K2:K3];

    logic [FB:0]           s_sel;
    logic [FB:0]           t_sel;
    logic signed [PRW-1:0] sp_reg [4];
    logic signed [DW-1:0]  rp_reg [2];
    logic [FB:0]           st_reg [K3+1:K3+4][2];
    logic signed [QW-1:0]  dx_reg;
    logic signed [QW-1:0]  dy_reg;
    logic signed [2*QW-1:0] p_dx;
    logic signed [2*QW-1:0] p_dy;
    logic [SW-1:0]         sum_next;
    logic [SW-1:0]         shifted_next;

    logic [ssd_pkg::DIST_W-1:0]  dist_reg;
    logic [ssd_pkg::PARAM_W-1:0] sout_reg;
    logic [ssd_pkg::PARAM_W-1:0] tout_reg;

    // whole pipeline moves unless a finished word is held back
    assign pipe_en = !vld_reg[N] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = vld_reg[N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[N-1:1], s_valid};
        end
    end

    // front end: differences, products, dot products
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            geo_reg[1][G_D1X] <= DW'(s_first_end_x) - DW'(s_first_start_x);
            geo_reg[1][G_D1Y] <= DW'(s_first_end_y) - DW'(s_first_start_y);
            geo_reg[1][G_D2X] <= DW'(s_second_end_x) - DW'(s_second_start_x);
            geo_reg[1][G_D2Y] <= DW'(s_second_end_y) - DW'(s_second_start_y);
            geo_reg[1][G_RX]  <= DW'(s_first_start_x) - DW'(s_second_start_x);
            geo_reg[1][G_RY]  <= DW'(s_first_start_y) - DW'(s_second_start_y);
            for (int k = 2; k <= K3; k++) begin
                geo_reg[k] <= geo_reg[k-1];
            end

            prod_reg[0] <= geo_reg[1][G_D1X] * geo_reg[1][G_D1X];
            prod_reg[1] <= geo_reg[1][G_D1Y] * geo_reg[1][G_D1Y];
            prod_reg[2] <= geo_reg[1][G_D2X] * geo_reg[1][G_D2X];
            prod_reg[3] <= geo_reg[1][G_D2Y] * geo_reg[1][G_D2Y];
            prod_reg[4] <= geo_reg[1][G_D2X] * geo_reg[1][G_RX];
            prod_reg[5] <= geo_reg[1][G_D2Y] * geo_reg[1][G_RY];
            prod_reg[6] <= geo_reg[1][G_D1X] * geo_reg[1][G_RX];
            prod_reg[7] <= geo_reg[1][G_D1Y] * geo_reg[1][G_RY];
            prod_reg[8] <= geo_reg[1][G_D1X] * geo_reg[1][G_D2X];
            prod_reg[9] <= geo_reg[1][G_D1Y] * geo_reg[1][G_D2Y];

            coef_reg[3][C_A] <= prod_reg[0] + prod_reg[1];
            coef_reg[3][C_E] <= prod_reg[2] + prod_reg[3];
            coef_reg[3][C_F] <= prod_reg[4] + prod_reg[5];
            coef_reg[3][C_C] <= prod_reg[6] + prod_reg[7];
            coef_reg[3][C_B] <= prod_reg[8] + prod_reg[9];
            for (int k = 4; k <= K1 + 2; k++) begin
                coef_reg[k] <= coef_reg[k-1];
            end
        end
    end

    // cross products for the unclamped s
    ssd_mul #(.W(PW)) u_mul_ae (
        .aclk(aclk), .en(pipe_en),
        .a(coef_reg[3][C_A]), .b(coef_reg[3][C_E]), .p(p_ae)
    );
    ssd_mul #(.W(PW)) u_mul_bb (
        .aclk(aclk), .en(pipe_en),
        .a(coef_reg[3][C_B]), .b(coef_reg[3][C_B]), .p(p_bb)
    );
    ssd_mul #(.W(PW)) u_mul_bf (
        .aclk(aclk), .en(pipe_en),
        .a(coef_reg[3][C_B]), .b(coef_reg[3][C_F]), .p(p_bf)
    );
    ssd_mul #(.W(PW)) u_mul_ce (
        .aclk(aclk), .en(pipe_en),
        .a(coef_reg[3][C_C]), .b(coef_reg[3][C_E]), .p(p_ce)
    );

    // divider operands; a parallel pair forces s to zero
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            den_reg <= NW'(p_ae) - NW'(p_bb);
            n1_reg  <= (p_ae == p_bb) ? '0 : NW'(p_bf) - NW'(p_ce);
            nlo_reg <= -AW'(coef_reg[5][C_C]);
            nhi_reg <= AW'(coef_reg[5][C_B]) - AW'(coef_reg[5][C_C]);
            zf_reg[6][Z_A] <= (coef_reg[5][C_A] == '0);
            zf_reg[6][Z_E] <= (coef_reg[5][C_E] == '0);
            for (int k = 7; k <= K3; k++) begin
                zf_reg[k] <= zf_reg[k-1];
            end
        end
    end

    // s from the full solve, the two clamped-t fallbacks, t of a point
    ssd_div #(.W(NW), .FB(FB)) u_div_s1 (
        .aclk(aclk), .en(pipe_en),
        .num(n1_reg), .den(den_reg), .q(q_s1)
    );
    ssd_div #(.W(AW), .FB(FB)) u_div_lo (
        .aclk(aclk), .en(pipe_en),
        .num(nlo_reg), .den(AW'(coef_reg[6][C_A])), .q(q_lo)
    );
    ssd_div #(.W(AW), .FB(FB)) u_div_hi (
        .aclk(aclk), .en(pipe_en),
        .num(nhi_reg), .den(AW'(coef_reg[6][C_A])), .q(q_hi)
    );
    ssd_div #(.W(AW), .FB(FB)) u_div_deg (
        .aclk(aclk), .en(pipe_en),
        .num(AW'(coef_reg[6][C_F])), .den(AW'(coef_reg[6][C_E])), .q(q_deg)
    );

    // b times s for the t numerator
    ssd_mul #(.W(BSW)) u_mul_bs (
        .aclk(aclk), .en(pipe_en),
        .a(BSW'(coef_reg[K1][C_B])), .b(BSW'(q_s1)), .p(p_bs)
    );

    always_comb begin
        tn_next     = TW'(p_bs) + (TW'(coef_reg[K1+2][C_F]) <<< FB);
        trange_next = TW'($unsigned(coef_reg[K1+2][C_E])) << FB;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sel_reg[K1+1][S_S1]  <= q_s1;
            sel_reg[K1+1][S_LO]  <= q_lo;
            sel_reg[K1+1][S_HI]  <= q_hi;
            sel_reg[K1+1][S_DEG] <= q_deg;
            for (int k = K1 + 2; k <= K3; k++) begin
                sel_reg[k] <= sel_reg[k-1];
            end
            tn_reg     <= tn_next;
            trange_reg <= trange_next;
            // t below zero or above one decides which s is recomputed
            tf_reg[K2][TF_NEG]   <= tn_next[TW-1];
            tf_reg[K2][TF_ABOVE] <= tn_next > $signed(trange_next);
            for (int k = K2 + 1; k <= K3; k++) begin
                tf_reg[k] <= tf_reg[k-1];
            end
        end
    end

    // t from the truncated s; clamps itself at both ends
    ssd_div #(.W(TW), .FB(FB)) u_div_t (
        .aclk(aclk), .en(pipe_en),
        .num(tn_reg), .den(trange_reg), .q(q_t)
    );

    // pick s and t for the degenerate and clamped cases
    always_comb begin
        s_sel = sel_reg[K3][S_S1];
        t_sel = q_t;
        if (zf_reg[K3][Z_A] && zf_reg[K3][Z_E]) begin
            s_sel = '0;
            t_sel = '0;
        end else if (zf_reg[K3][Z_A]) begin
            s_sel = '0;
            t_sel = sel_reg[K3][S_DEG];
        end else if (zf_reg[K3][Z_E]) begin
            s_sel = sel_reg[K3][S_LO];
            t_sel = '0;
        end else if (tf_reg[K3][TF_NEG]) begin
            s_sel = sel_reg[K3][S_LO];
        end else if (tf_reg[K3][TF_ABOVE]) begin
            s_sel = sel_reg[K3][S_HI];
        end
    end

    // closest point difference r + d1*s - d2*t in q.frac
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sp_reg[0] <= geo_reg[K3][G_D1X] * $signed({1'b0, s_sel});
            sp_reg[1] <= geo_reg[K3][G_D1Y] * $signed({1'b0, s_sel});
            sp_reg[2] <= geo_reg[K3][G_D2X] * $signed({1'b0, t_sel});
            sp_reg[3] <= geo_reg[K3][G_D2Y] * $signed({1'b0, t_sel});
            rp_reg[0] <= geo_reg[K3][G_RX];
            rp_reg[1] <= geo_reg[K3][G_RY];
            st_reg[K3+1][0] <= s_sel;
            st_reg[K3+1][1] <= t_sel;
            for (int k = K3 + 2; k <= K3 + 4; k++) begin
                st_reg[k] <= st_reg[k-1];
            end
            dx_reg <= (QW'(rp_reg[0]) <<< FB) + QW'(sp_reg[0]) - QW'(sp_reg[2]);
            dy_reg <= (QW'(rp_reg[1]) <<< FB) + QW'(sp_reg[1]) - QW'(sp_reg[3]);
        end
    end

    ssd_mul #(.W(QW)) u_mul_dx (
        .aclk(aclk), .en(pipe_en), .a(dx_reg), .b(dx_reg), .p(p_dx)
    );
    ssd_mul #(.W(QW)) u_mul_dy (
        .aclk(aclk), .en(pipe_en), .a(dy_reg), .b(dy_reg), .p(p_dy)
    );

    // sum of squares, drop to 8 fractional bits, saturate
    always_comb begin
        sum_next     = SW'($unsigned(p_dx)) + SW'($unsigned(p_dy));
        shifted_next = sum_next >> DSHIFT;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dist_reg <= (shifted_next > SW'(ssd_pkg::DIST_MAX)) ?
                        ssd_pkg::DIST_MAX : ssd_pkg::DIST_W'(shifted_next);
            sout_reg <= ssd_pkg::PARAM_W'(st_reg[K3+4][0]);
            tout_reg <= ssd_pkg::PARAM_W'(st_reg[K3+4][1]);
        end
    end

    assign m_distance_squared = dist_reg;
    assign m_first_param      = sout_reg;
    assign m_second_param     = tout_reg;

    // a stalled pipeline keeps every valid bit in place
    `SSD_ASSERT(a_stall_freeze, aclk, aresetn, !pipe_en |=> $stable(vld_reg))
    // t cannot be both below zero and above one
    `SSD_ASSERT_IMPL(a_t_excl, aclk, aresetn, vld_reg[K2], !(tf_reg[K2][TF_NEG] && tf_reg[K2][TF_ABOVE]))
    // chosen parameters stay within [0, 1]
    `SSD_ASSERT_IMPL(a_param_rng, aclk, aresetn, vld_reg[K3+1], (st_reg[K3+1][0] <= ONE) && (st_reg[K3+1][1] <= ONE))
    // a point for the first segment pins s at zero
    `SSD_ASSERT_IMPL(a_deg_s, aclk, aresetn, vld_reg[K3] && zf_reg[K3][Z_A], s_sel == '0)

endmodule

/* sim/segment_segment_distance_squared_top_tb.sv */
`timescale 1ns / 100ps

module segment_segment_distance_squared_top_tb;

    localparam int  CW         = 16;
    localparam int  FRAC       = 16;
    localparam int  N_RANDOM   = 1725;
    localparam int  LATENCY    = 2 * FRAC + 16;
    localparam int  CYCLE_MAX  = 400000;
    localparam int  HOLDOFF    = 300;
    localparam int  IDLE_PCT   = 11;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    // one expected result word
    typedef struct {
        logic [ssd_pkg::DIST_W-1:0]  dsq;
        logic [ssd_pkg::PARAM_W-1:0] s_par;
        logic [ssd_pkg::PARAM_W-1:0] t_par;
    } closest_t;

    // predicts closest points and checks results in order
    class closest_scoreboard;
        closest_t pending_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // clamp(num/den) to [0,1] in q1.frac, truncated
        static function wide_t clamp_ratio(wide_t num, wide_t den);
            if (num <= 0) return 0;
            if (num >= den) return wide_t'(1) <<< FRAC;
            return (num <<< FRAC) / den;
        endfunction

        function void note(coord_t pt[8]);
            wide_t    one, p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
            wide_t    d1x, d1y, d2x, d2y, rx, ry, a, e, f, c, b;
            wide_t    s, t, den, tn, trange, dx, dy, sum;
            closest_t res;
            one = wide_t'(1) <<< FRAC;
            p0x = pt[0]; p0y = pt[1]; p1x = pt[2]; p1y = pt[3];
            q0x = pt[4]; q0y = pt[5]; q1x = pt[6]; q1y = pt[7];
            d1x = p1x - p0x; d1y = p1y - p0y;
            d2x = q1x - q0x; d2y = q1y - q0y;
            rx = p0x - q0x;  ry = p0y - q0y;
            a = d1x * d1x + d1y * d1y;
            e = d2x * d2x + d2y * d2y;
            f = d2x * rx + d2y * ry;
            c = d1x * rx + d1y * ry;
            b = d1x * d2x + d1y * d2y;
            s = 0;
            t = 0;
            if (a == 0 && e == 0) begin
                s = 0;
                t = 0;
            end else if (a == 0) begin
                t = clamp_ratio(f, e);
            end else if (e == 0) begin
                s = clamp_ratio(-c, a);
            end else begin
                den = a * e - b * b;
                s = (den > 0) ? clamp_ratio(b * f - c * e, den) : 0;
                tn = b * s + f * one;
                trange = e * one;
                if (tn < 0) begin
                    t = 0;
                    s = clamp_ratio(-c, a);
                end else if (trange - tn < 0) begin
                    t = one;
                    s = clamp_ratio(b - c, a);
                end else begin
                    t = clamp_ratio(tn, trange);
                end
            end
            dx = rx * one + d1x * s - d2x * t;
            dy = ry * one + d1y * s - d2y * t;
            sum = (dx * dx + dy * dy) >>> (2 * FRAC - ssd_pkg::DIST_FRAC_BITS);
            res.dsq   = (sum > wide_t'(ssd_pkg::DIST_MAX)) ?
                        ssd_pkg::DIST_MAX : sum[ssd_pkg::DIST_W-1:0];
            res.s_par = s[ssd_pkg::PARAM_W-1:0];
            res.t_par = t[ssd_pkg::PARAM_W-1:0];
            pending_q.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(closest_t got);
            closest_t want;
            if (pending_q.size() == 0) begin
                report("unexpected word", '0, '0);
                return;
            end
            want = pending_q.pop_front();
            if (got.dsq !== want.dsq)
                report("distance_squared", 64'(got.dsq), 64'(want.dsq));
            if (got.s_par !== want.s_par)
                report("first_param", 64'(got.s_par), 64'(want.s_par));
            if (got.t_par !== want.t_par)
                report("second_param", 64'(got.t_par), 64'(want.t_par));
        endtask
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    coord_t                       pt[8] = '{default: '0};
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [ssd_pkg::DIST_W-1:0]   m_distance_squared;
    logic [ssd_pkg::PARAM_W-1:0]  m_first_param;
    logic [ssd_pkg::PARAM_W-1:0]  m_second_param;

    closest_scoreboard   sb = new();
    int                  cycles = 0;
    bit                  no_idle = 1'b0;   // quiet stretch on both sides
    bit                  holdoff_req = 1'b0;
    bit                  holdoff_done = 1'b0;

    always #5 aclk = ~aclk;

    segment_segment_distance_squared_top uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_start_x    (pt[0]),
        .s_first_start_y    (pt[1]),
        .s_first_end_x      (pt[2]),
        .s_first_end_y      (pt[3]),
        .s_second_start_x   (pt[4]),
        .s_second_start_y   (pt[5]),
        .s_second_end_x     (pt[6]),
        .s_second_end_y     (pt[7]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_distance_squared (m_distance_squared),
        .m_first_param      (m_first_param),
        .m_second_param     (m_second_param)
    );

    // watch both handshakes at the rising edge
    always @(posedge aclk) begin
        closest_t got;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) sb.note(pt);
        if (aresetn && m_valid && m_ready) begin
            got.dsq   = m_distance_squared;
            got.s_par = m_first_param;
            got.t_par = m_second_param;
            sb.check(got);
        end
    end

    // overall watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (holdoff_req && !holdoff_done) begin
            m_ready <= 1'b0;
            for (int i = 0; i < HOLDOFF; i++) @(negedge aclk);
            holdoff_done <= 1'b1;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one word and hold it until accepted; returns at a falling edge
    task send_word(coord_t w[8]);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 8; i++) pt[i] <= w[i];
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task send_pts(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
        coord_t w[8];
        w[0] = coord_t'(v0); w[1] = coord_t'(v1);
        w[2] = coord_t'(v2); w[3] = coord_t'(v3);
        w[4] = coord_t'(v4); w[5] = coord_t'(v5);
        w[6] = coord_t'(v6); w[7] = coord_t'(v7);
        send_word(w);
    endtask

    // random coordinate: mostly small so the clamps and the interior both show up
    function automatic coord_t rand_coord(int mode);
        case (mode)
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(64) - 32);
            default: return coord_t'($urandom_range(4000) - 2000);
        endcase
    endfunction

    task send_random();
        coord_t w[8];
        int     mode;
        int     kind;
        mode = $urandom_range(2);
        for (int i = 0; i < 8; i++) w[i] = rand_coord(mode);
        kind = $urandom_range(9);
        case (kind)
            0: begin   // first segment a point
                w[2] = w[0]; w[3] = w[1];
            end
            1: begin   // second segment a point
                w[6] = w[4]; w[7] = w[5];
            end
            2: begin   // parallel: same direction, scaled
                w[6] = coord_t'(w[4] + 2 * (w[2] - w[0]));
                w[7] = coord_t'(w[5] + 2 * (w[3] - w[1]));
            end
            3: begin   // both points
                w[2] = w[0]; w[3] = w[1]; w[6] = w[4]; w[7] = w[5];
            end
            default: ;
        endcase
        send_word(w);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words: extremes and each special case
        send_pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_pts(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pts(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        send_pts(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
        send_pts(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
        send_pts(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
        send_pts(5, 5, 5, 5, 0, 0, 10, 0);          // first a point
        send_pts(0, 0, 10, 0, 5, 5, 5, 5);          // second a point
        send_pts(3, 4, 3, 4, 0, 0, 0, 0);           // both points
        send_pts(0, 0, 10, 0, 0, 3, 10, 3);         // parallel overlap
        send_pts(0, 0, 10, 0, 20, 3, 30, 3);        // parallel disjoint
        send_pts(0, 0, 10, 10, 0, 10, 10, 0);       // crossing
        send_pts(0, 0, 10, 0, 5, 2, 5, 20);         // t below range
        send_pts(0, 0, 10, 0, 5, 20, 5, 2);         // t above range
        send_pts(0, 0, 3, 7, 11, -5, 2, 9);
        send_pts(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        send_pts(32767, -32768, -32768, 32767, 1, 1, -1, -1);
        send_pts(0, 0, 1, 0, 0, 0, 0, 1);
        send_pts(-1, -1, 1, 1, -1, 1, 1, -1);
        send_pts(100, 0, 0, 0, -3, 7, -50, 7);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) begin
                // let the pipeline fill and stall while the sender keeps offering
                holdoff_req <= 1'b1;
            end
            if (n == 700) begin
                // sender pause until everything has drained
                s_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(negedge aclk);
            end
            if (n == 900) no_idle <= 1'b1;
            if (n == 1200) no_idle <= 1'b0;
            send_random();
        end
        s_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
